// File: sv/fslfa_pkg.sv
`timescale 1ns / 1ps

package fslfa_pkg;

	localparam int unsigned POOL_SLOTS_DEF = 1024;
	localparam int unsigned SLOT_W = 10;
	localparam int unsigned COUNT_W = 4;

	localparam logic [COUNT_W-1:0] ONE_SLOT = COUNT_W'(1);

	typedef enum logic {
		FN_ALLOC = 1'b0,
		FN_FREE  = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_COUNT = 2'd1,
		ST_EXHAUSTED = 2'd2
	} status_t;

	typedef struct packed {
		func_t               func;
		logic [SLOT_W-1:0]   slot_index;
		logic [COUNT_W-1:0]  slot_count;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] granted_slot;
		status_t           status;
	} rsp_t;

	// one entry of the link memory
	typedef struct packed {
		logic              last;
		logic [SLOT_W-1:0] link;
	} link_entry_t;

endpackage

// File: sv/fslfa_ram.sv
`timescale 1ns / 1ps

module fslfa_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/fixed_slot_free_list_allocator_core.sv
`timescale 1ns / 1ps
// result: a free, a fresh-slot allocate or a rejected item gives its registered result
// the cycle after it is taken; an allocate served from the freed list answers from S_POP
// throughput: one item per cycle unless rsp_stall holds the response; an allocate
// from the freed list waits in S_POP for the registered link-memory read at the list head
// reset: empty freed list, no slot handed out; link memory needs no clearing

module fixed_slot_free_list_allocator_core
	import fslfa_pkg::*;
#(
	parameter int unsigned POOL_SLOTS = POOL_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int unsigned AW = $clog2(POOL_SLOTS);
	localparam int unsigned FW = $clog2(POOL_SLOTS + 1);
	localparam logic [FW-1:0] FRESH_END = FW'(POOL_SLOTS);

	typedef enum logic {
		S_IDLE,
		S_POP
	} state_t;

	state_t            state_q;
	logic [SLOT_W-1:0] head_q;
	logic              nonempty_q;
	logic [FW-1:0]     fresh_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic        accept;
	logic        idx_ok;
	logic        head_ok;
	logic        mem_we;
	logic        mem_re;
	logic        rsp_load;
	link_entry_t wr_entry;
	link_entry_t rd_entry;

	assign req_stall = (state_q != S_IDLE) || (rsp_valid_q && rsp_stall);
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign idx_ok  = 32'(req.slot_index) < POOL_SLOTS;
	assign head_ok = nonempty_q && (32'(head_q) < POOL_SLOTS);

	assign mem_we = accept && req.slot_count == ONE_SLOT && req.func == FN_FREE && idx_ok;
	assign mem_re = accept && req.slot_count == ONE_SLOT && req.func == FN_ALLOC && head_ok;

	// every taken item answers at once except a pop, which answers from S_POP
	assign rsp_load = (state_q == S_POP) || (accept && !mem_re);

	assign wr_entry.link = head_q;
	assign wr_entry.last = !nonempty_q;

	fslfa_ram #(
		.WIDTH($bits(link_entry_t)),
		.DEPTH(POOL_SLOTS)
	) u_link_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(AW'(req.slot_index)),
		.wdata(wr_entry),
		.re   (mem_re),
		.raddr(AW'(head_q)),
		.rdata(rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			nonempty_q  <= 1'b0;
			fresh_q     <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.slot_count != ONE_SLOT) begin
							rsp_q.granted_slot <= '0;
							rsp_q.status       <= ST_BAD_COUNT;
						end else if (req.func == FN_FREE) begin
							rsp_q.granted_slot <= '0;
							if (idx_ok) begin
								head_q       <= req.slot_index;
								nonempty_q   <= 1'b1;
								rsp_q.status <= ST_OK;
							end else begin
								rsp_q.status <= ST_BAD_COUNT;
							end
						end else if (head_ok) begin
							// link of the head comes back next cycle
							state_q <= S_POP;
						end else if (fresh_q < FRESH_END) begin
							rsp_q.granted_slot <= SLOT_W'(fresh_q);
							rsp_q.status       <= ST_OK;
							fresh_q            <= fresh_q + FW'(1);
						end else begin
							rsp_q.granted_slot <= '0;
							rsp_q.status       <= ST_EXHAUSTED;
						end
					end
				end
				S_POP: begin
					rsp_q.granted_slot <= head_q;
					rsp_q.status       <= ST_OK;
					head_q             <= rd_entry.link;
					nonempty_q         <= !rd_entry.last;
					state_q            <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
